// ----- rtl/touch_pad_edge_to_midi_events_top_defines.svh -----
// ---------------------------------------------------------------------------
// touch pad edge to midi events: assertion macros
// concurrent checks clocked on clk, held off while rst_n is low
// ---------------------------------------------------------------------------
`ifndef TOUCH_PAD_EDGE_TO_MIDI_EVENTS_TOP_DEFINES_SVH
`define TOUCH_PAD_EDGE_TO_MIDI_EVENTS_TOP_DEFINES_SVH

// same-cycle implication
`define TPME_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpme: same-cycle check failed");

// next-cycle implication
`define TPME_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpme: next-cycle check failed");

`endif

// ----- rtl/tpme_pkg.sv -----
// ---------------------------------------------------------------------------
// tpme_pkg
// types and constants shared by the touch pad edge to midi event block
// ---------------------------------------------------------------------------
package tpme_pkg;

    localparam int MASK_W        = 12;
    localparam int PAD_COUNT_DEF = 12;
    localparam int PAD_W         = 4;
    localparam int DATA_W        = 7;
    localparam int CH_W          = 5;
    localparam int CFG_W         = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int S_TDATA_W     = 16;
    localparam int M_FIELDS_W    = 2 + CH_W + DATA_W + DATA_W + PAD_W;
    localparam int M_TDATA_W     = 32;

    localparam logic [DATA_W-1:0] DATA_MAX      = 7'd127;
    localparam logic [DATA_W-1:0] NOTE_VELOCITY = 7'd100;
    localparam logic [CH_W-1:0]   CH_MIN        = 5'd1;
    localparam logic [CH_W-1:0]   CH_MAX        = 5'd16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_NOTE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CC_MODE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OSC_ENABLE = 2'd3;

    typedef enum logic [1:0] {
        KIND_NOTE_ON  = 2'd0,
        KIND_NOTE_OFF = 2'd1,
        KIND_CC       = 2'd2
    } kind_t;

    typedef struct packed {
        logic [CFG_W-1:0]  chan_set;
        logic [DATA_W-1:0] first_note;
        logic              cc_mode;
        logic              osc_enable;
    } cfg_t;

    // one pad change picked by the scanner
    typedef struct packed {
        logic             valid;
        logic [PAD_W-1:0] pad;
        logic             rising;
        logic             last;
    } scan_evt_t;

    typedef struct packed {
        kind_t             kind;
        logic [CH_W-1:0]   channel;
        logic [DATA_W-1:0] data_one;
        logic [DATA_W-1:0] data_two;
        logic [PAD_W-1:0]  pad;
        logic              to_osc;
        logic              last;
    } event_t;

endpackage

// ----- rtl/touch_pad_edge_to_midi_events_top.sv -----
// a taken mask word starts the pad scan counter at pad 0; each changed pad's event is
// registered into the output slot as the counter passes it; throughput: one pad per cycle
// while the output slot is free or draining; s_tready stays low until the highest changed
// pad is scanned, and an unchanged mask gives no word and s_tready stays high
// reset: rst_n low clears the stored mask and output valid, registers take channel 1,
// base note 60, note mode, osc off; no clearing pass
// ---------------------------------------------------------------------------
// touch_pad_edge_to_midi_events_top
// turns touch mask edges into midi note or control change event words
// ---------------------------------------------------------------------------
`include "touch_pad_edge_to_midi_events_top_defines.svh"

module touch_pad_edge_to_midi_events_top #(
    parameter int PAD_COUNT = tpme_pkg::PAD_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [11:0] touch_mask
    input  logic [tpme_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] message_kind, [6:2] channel, [13:7] data_one, [20:14] data_two,
    // [24:21] pad_index
    output logic [tpme_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] to_osc
    output logic [0:0]                     m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [tpme_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpme_pkg::CFG_W-1:0]     cfg_data
);
    import tpme_pkg::*;

    cfg_t      cfg_reg;
    event_t    out_reg;
    logic      out_valid_reg;
    scan_evt_t se;
    event_t    ev;
    logic      step;
    logic      scan_ready;
    logic      scan_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chan_set   <= CFG_W'(1);
            cfg_reg.first_note <= DATA_W'(60);
            cfg_reg.cc_mode    <= 1'b0;
            cfg_reg.osc_enable <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CHANNEL:    cfg_reg.chan_set   <= cfg_data;
                REG_FIRST_NOTE: cfg_reg.first_note <= cfg_data[DATA_W-1:0];
                REG_CC_MODE:    cfg_reg.cc_mode    <= cfg_data[0];
                REG_OSC_ENABLE: cfg_reg.osc_enable <= cfg_data[0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // scanner only moves on when the output slot is free or draining
    assign step = !out_valid_reg || m_tready;

    tpme_scan #(
        .PAD_COUNT(PAD_COUNT)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_mask   (s_tdata[MASK_W-1:0]),
        .in_ready  (scan_ready),
        .clear_prev(cfg_we),
        .step      (step),
        .evt       (se)
    );

    tpme_event u_event (
        .cfg(cfg_reg),
        .se (se),
        .ev (ev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (se.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (se.valid)
        begin
            out_reg <= ev;
        end
    end

    assign s_tready  = scan_ready;
    assign scan_busy = !scan_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {(M_TDATA_W - M_FIELDS_W)'(0), out_reg.pad, out_reg.data_two,
                        out_reg.data_one, out_reg.channel, out_reg.kind};
    assign m_tuser   = out_reg.to_osc;
    assign m_tlast   = out_reg.last;

    // a waiting word that is not the last one means pads are still pending
    `TPME_ASSERT_IMPLY(a_mid_run_busy, m_tvalid && !m_tlast, scan_busy)
    // the scanner only starts on a taken mask word
    `TPME_ASSERT_IMPLY(a_busy_from_accept, $rose(scan_busy), $past(s_tvalid && s_tready))
    // a stalled word holds still until it is taken
    `TPME_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `TPME_ASSERT_IMPLY(a_channel_range, m_tvalid,
        out_reg.channel >= CH_MIN && out_reg.channel <= CH_MAX)

endmodule

// ----- rtl/tpme_scan.sv -----
// ---------------------------------------------------------------------------
// tpme_scan
// pad scan sequencer: keeps the previous mask and walks the changed pads
// ---------------------------------------------------------------------------
module tpme_scan #(
    parameter int PAD_COUNT = tpme_pkg::PAD_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [tpme_pkg::MASK_W-1:0] in_mask,
    output logic                        in_ready,
    input  logic                        clear_prev,
    input  logic                        step,
    output tpme_pkg::scan_evt_t         evt
);
    import tpme_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t            state_reg;
    logic [MASK_W-1:0] prev_reg;
    logic [MASK_W-1:0] cur_reg;
    logic [MASK_W-1:0] pend_reg;
    logic [PAD_W-1:0]  pad_reg;

    logic [MASK_W-1:0] pad_lim;
    logic [MASK_W-1:0] diff;
    logic [MASK_W-1:0] pend_clr;

    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            pad_lim[i] = (i < PAD_COUNT);
        end
    end

    assign diff     = (in_mask ^ prev_reg) & pad_lim;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        pend_clr          = pend_reg;
        pend_clr[pad_reg] = 1'b0;
    end

    assign evt.valid  = (state_reg == S_SCAN) && step && pend_reg[pad_reg];
    assign evt.pad    = pad_reg;
    assign evt.rising = cur_reg[pad_reg];
    assign evt.last   = (pend_clr == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            prev_reg  <= '0;
            cur_reg   <= '0;
            pend_reg  <= '0;
            pad_reg   <= '0;
        end
        else
        begin
            if (clear_prev)
            begin
                prev_reg <= '0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        prev_reg <= in_mask;
                        cur_reg  <= in_mask;
                        pend_reg <= diff;
                        pad_reg  <= '0;
                        if (diff != '0)
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (step)
                    begin
                        pend_reg <= pend_clr;
                        pad_reg  <= pad_reg + PAD_W'(1);
                        if (pend_clr == '0)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/tpme_event.sv -----
// ---------------------------------------------------------------------------
// tpme_event
// shared event unit: note number add and saturate, channel clamp, data bytes
// ---------------------------------------------------------------------------
module tpme_event (
    input  tpme_pkg::cfg_t      cfg,
    input  tpme_pkg::scan_evt_t se,
    output tpme_pkg::event_t    ev
);
    import tpme_pkg::*;

    logic [DATA_W:0] note_sum;

    assign note_sum = {1'b0, cfg.first_note} + (DATA_W + 1)'(se.pad);

    always_comb
    begin
        ev.pad    = se.pad;
        ev.to_osc = cfg.osc_enable;
        ev.last   = se.last;

        ev.data_one = note_sum[DATA_W] ? DATA_MAX : note_sum[DATA_W-1:0];

        if (cfg.chan_set == '0)
        begin
            ev.channel = CH_MIN;
        end
        else if (cfg.chan_set > CFG_W'(CH_MAX))
        begin
            ev.channel = CH_MAX;
        end
        else
        begin
            ev.channel = cfg.chan_set[CH_W-1:0];
        end

        if (cfg.cc_mode)
        begin
            ev.kind     = KIND_CC;
            ev.data_two = se.rising ? DATA_MAX : '0;
        end
        else
        begin
            ev.kind     = se.rising ? KIND_NOTE_ON : KIND_NOTE_OFF;
            ev.data_two = se.rising ? NOTE_VELOCITY : '0;
        end
    end

endmodule

// ----- test/touch_pad_edge_to_midi_events_top_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// touch_pad_edge_to_midi_events_top_test
// drives touch mask words into the block and checks every midi event word
// against a local edge-scan predictor; covers channel clamping, note
// saturation, control change mode, osc marking, the mask clear on register
// writes, random mask sequences and a long output stall
// ---------------------------------------------------------------------------
module touch_pad_edge_to_midi_events_top_test;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    // [11:0] touch_mask
    logic [tpme_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    // [1:0] message_kind, [6:2] channel, [13:7] data_one, [20:14] data_two,
    // [24:21] pad_index
    logic [tpme_pkg::M_TDATA_W-1:0] m_tdata;
    // [0] to_osc
    logic [0:0]                     m_tuser;
    logic                           m_tlast;
    logic                           cfg_we;
    logic [tpme_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tpme_pkg::CFG_W-1:0]     cfg_data;

    // predictor copy of the registers and the stored mask
    logic [7:0]  chan_setting;
    logic [6:0]  base_setting;
    logic        cc_setting;
    logic        osc_setting;
    logic [11:0] held_mask;

    tpme_pkg::event_t pending_events[$];

    int  fail_count;
    int  masks_sent;
    int  events_checked;
    int  reg_writes;
    bit  tx_idle_en;
    bit  rx_idle_en;
    int  rx_hold_cycles;
    int  rx_burst;

    touch_pad_edge_to_midi_events_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL touch_pad_edge_to_midi_events_top");
        $finish;
    end

    // edge scan of one accepted mask, pads in ascending order
    function automatic void predict_midi_events(logic [11:0] now_mask);
        tpme_pkg::event_t found[$];
        tpme_pkg::event_t ev;
        logic [4:0] ch;
        int note;
        bit rising;
        begin
            ch = (chan_setting == 8'd0) ? 5'd1 :
                 (chan_setting > 8'd16) ? 5'd16 : chan_setting[4:0];
            for (int i = 0; i < 12; i++)
            begin
                if (now_mask[i] != held_mask[i])
                begin
                    rising = now_mask[i];
                    note = int'(base_setting) + i;
                    if (note > 127)
                        note = 127;
                    if (cc_setting)
                    begin
                        ev.kind     = tpme_pkg::KIND_CC;
                        ev.data_two = rising ? 7'd127 : 7'd0;
                    end
                    else
                    begin
                        ev.kind     = rising ? tpme_pkg::KIND_NOTE_ON : tpme_pkg::KIND_NOTE_OFF;
                        ev.data_two = rising ? 7'd100 : 7'd0;
                    end
                    ev.channel  = ch;
                    ev.data_one = note[6:0];
                    ev.pad      = i[3:0];
                    ev.to_osc   = osc_setting;
                    ev.last     = 1'b0;
                    found.push_back(ev);
                end
            end
            if (found.size() > 0)
                found[found.size()-1].last = 1'b1;
            foreach (found[k])
                pending_events.push_back(found[k]);
            held_mask = now_mask;
        end
    endfunction

    task automatic check_field(string name, int expected, int actual);
        if (expected != actual)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
            fail_count++;
        end
    endtask

    // event word checker
    initial
    begin
        tpme_pkg::event_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_events.size() == 0)
                begin
                    $error("unexpected event word %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    check_field("message_kind", want.kind, m_tdata[1:0]);
                    check_field("channel", want.channel, m_tdata[6:2]);
                    check_field("data_one", want.data_one, m_tdata[13:7]);
                    check_field("data_two", want.data_two, m_tdata[20:14]);
                    check_field("pad_index", want.pad, m_tdata[24:21]);
                    check_field("to_osc", want.to_osc, m_tuser[0]);
                    check_field("last_event", want.last, m_tlast);
                    events_checked++;
                end
            end
        end
    end

    // receiver: random stall bursts, or a long hold-off when asked
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge clk);
                rx_hold_cycles = 0;
                m_tready <= 1'b1;
            end
            else if (rx_idle_en && (rx_burst > 0 || $urandom_range(0, 5) == 0))
            begin
                if (rx_burst == 0)
                    rx_burst = $urandom_range(1, 5);
                m_tready <= 1'b0;
                rx_burst--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic push_mask(logic [11:0] mask);
        int gap;
        begin
            gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
            @(negedge clk);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {4'd0, mask};
            do
                @(posedge clk);
            while (!s_tready);
            predict_midi_events(mask);
            masks_sent++;
        end
    endtask

    // stop offering, let every event arrive, then cover the scan tail
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            tpme_pkg::REG_CHANNEL:    chan_setting = value;
            tpme_pkg::REG_FIRST_NOTE: base_setting = value[6:0];
            tpme_pkg::REG_CC_MODE:    cc_setting   = value[0];
            tpme_pkg::REG_OSC_ENABLE: osc_setting  = value[0];
            default: ;
        endcase
        held_mask = 12'd0;
        reg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        push_mask(12'h001);
        push_mask(12'hFFF);
        push_mask(12'hFFF);
        push_mask(12'h000);
        push_mask(12'h800);
        push_mask(12'hAAA);
        push_mask(12'h555);
        push_mask(12'h000);
        wait_idle();
    endtask

    task automatic test_channel_clamp();
        logic [7:0] settings[4] = '{8'd0, 8'd16, 8'd17, 8'd255};
        foreach (settings[k])
        begin
            write_reg(tpme_pkg::REG_CHANNEL, settings[k]);
            push_mask(12'h00F);
            push_mask(12'h000);
            wait_idle();
        end
    endtask

    task automatic test_note_saturation();
        write_reg(tpme_pkg::REG_FIRST_NOTE, 8'd127);
        push_mask(12'hFFF);
        push_mask(12'h000);
        wait_idle();
        write_reg(tpme_pkg::REG_FIRST_NOTE, 8'd116);
        push_mask(12'hFFF);
        wait_idle();
        // pads held across the write come back as rising edges
        write_reg(tpme_pkg::REG_FIRST_NOTE, 8'd0);
        push_mask(12'h801);
        wait_idle();
    endtask

    task automatic test_cc_mode();
        write_reg(tpme_pkg::REG_CC_MODE, 8'd1);
        write_reg(tpme_pkg::REG_OSC_ENABLE, 8'd1);
        push_mask(12'hFFF);
        push_mask(12'h000);
        push_mask(12'h3C3);
        wait_idle();
    endtask

    task automatic test_write_clears_mask();
        push_mask(12'h0F0);
        wait_idle();
        write_reg(tpme_pkg::REG_OSC_ENABLE, 8'd0);
        push_mask(12'h0F0);
        wait_idle();
        write_reg(tpme_pkg::REG_CC_MODE, 8'd0);
    endtask

    function automatic logic [11:0] next_random_mask();
        logic [11:0] flips;
        int sel;
        begin
            sel = $urandom_range(0, 9);
            flips = 12'd0;
            if (sel <= 5)
            begin
                repeat ($urandom_range(1, 3))
                    flips[$urandom_range(0, 11)] = 1'b1;
                return held_mask ^ flips;
            end
            case (sel)
                6: return 12'($urandom_range(0, 4095));
                7: return held_mask;
                8: return 12'h000;
                default: return 12'hFFF;
            endcase
        end
    endfunction

    task automatic random_reg_write();
        logic [1:0] idx;
        logic [7:0] value;
        int pick;
        begin
            idx  = 2'($urandom_range(0, 3));
            pick = $urandom_range(0, 5);
            case (idx)
                tpme_pkg::REG_CHANNEL:
                    value = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd1 : (pick == 2) ? 8'd16 :
                            (pick == 3) ? 8'd17 : (pick == 4) ? 8'd255 :
                            8'($urandom_range(0, 255));
                tpme_pkg::REG_FIRST_NOTE:
                    value = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd127 : (pick == 2) ? 8'd116 :
                            8'($urandom_range(0, 127));
                default:
                    value = 8'($urandom_range(0, 1));
            endcase
            wait_idle();
            write_reg(idx, value);
        end
    endtask

    task automatic test_random_masks(int count);
        int until_write;
        begin
            until_write = $urandom_range(20, 40);
            for (int n = 0; n < count; n++)
            begin
                until_write--;
                if (until_write == 0)
                begin
                    random_reg_write();
                    until_write = $urandom_range(20, 40);
                end
                push_mask(next_random_mask());
            end
            wait_idle();
        end
    endtask

    // receiver stops for a long while, sender keeps offering full swings
    task automatic test_output_stall();
        rx_hold_cycles = 300;
        for (int n = 0; n < 24; n++)
            push_mask((n % 2 == 0) ? 12'hFFF : 12'h000);
        wait_idle();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        chan_setting = 8'd1;
        base_setting = 7'd60;
        cc_setting   = 1'b0;
        osc_setting  = 1'b0;
        held_mask    = 12'd0;
        fail_count = 0;
        masks_sent = 0;
        events_checked = 0;
        reg_writes = 0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        rx_hold_cycles = 0;
        rx_burst = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_channel_clamp();
        test_note_saturation();
        test_cc_mode();
        test_write_clears_mask();
        test_random_masks(270);
        test_output_stall();
        // no idling from here on
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_masks(40);

        repeat (30) @(posedge clk);
        $display("run covered %0d mask words, %0d event words, %0d register writes",
                 masks_sent, events_checked, reg_writes);
        $display("incl. channel clamp, note saturation, cc/osc modes and a long output stall");
        if (fail_count == 0)
            $display("PASS touch_pad_edge_to_midi_events_top");
        else
            $display("FAIL touch_pad_edge_to_midi_events_top");
        $finish;
    end

endmodule
